### sv/circular_deque_assert.svh
// Assertion macros used by the deque top level.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef SYNTH
// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("deque assertion failed");
// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deque assertion failed");
// A condition that implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deque assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/cdq_pkg.sv
// Shared types and constants of the circular deque.
`default_nettype none
package cdq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ACT_W  = 2;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_REAR  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_REAR   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	// Operation broadcast to every cell; at most one bit is set, and only
	// for an operation that is legal in the current fill state.
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} cell_op_t;

endpackage
`default_nettype wire

### sv/cdq_cell.sv
// One storage cell of the deque shift chain.
`default_nettype none
module cdq_cell import cdq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_op_t              op,
	input  wire logic [DATA_WIDTH-1:0] push_data,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic                  left_valid,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	input  wire logic                  right_valid,
	output logic      [DATA_WIDTH-1:0] data_q,
	output logic                       valid_q,
	output logic      [DATA_WIDTH-1:0] tail_data
);

	logic [DATA_WIDTH-1:0] data_d;
	logic                  valid_d;
	logic                  is_tail;
	logic                  is_gap;

	// This cell holds the rear entry, or is the first free slot behind it.
	assign is_tail = valid_q && !right_valid;
	assign is_gap  = !valid_q && left_valid;

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		if (op.push_front) begin
			data_d  = left_data;
			valid_d = left_valid;
		end else if (op.push_rear) begin
			if (is_gap) begin
				data_d  = push_data;
				valid_d = 1'b1;
			end
		end else if (op.pop_front) begin
			data_d  = right_data;
			valid_d = right_valid;
		end else if (op.pop_rear) begin
			if (is_tail) begin
				valid_d = 1'b0;
			end
		end
	end

	assign tail_data = is_tail ? data_q : '0;

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

endmodule
`default_nettype wire

### sv/circular_deque.sv
// Top level of the double-ended queue built from a chain of storage cells.
//
// Use: a command beat is taken at a rising clock edge where start is high
// and busy is low. busy is held low, so a new command may be issued every
// cycle. The command carries action (push front, push rear, pop front,
// pop rear) and push_value, which only pushes use.
// Every command gives exactly one result beat, presented in the cycle after
// the command edge with done high for that single cycle: pop_value (the
// removed entry, zero for pushes and refused commands), status (done,
// overflow on a push into a full queue, underflow on a pop from an empty
// queue) and occupancy (entries held after the command).
// Throughput is one command per cycle; each command moves every cell of the
// chain by at most one place.
// The receiver cannot stall; a result beat not taken in its cycle is gone.
// Reset clears all valid bits and the entry count, so the queue starts
// empty; the entry data itself is not cleared.
// The front entry always sits in cell 0 and entries are packed toward it,
// so the valid bits form a thermometer code of the fill level.
`default_nettype none
`include "circular_deque_assert.svh"
module circular_deque import cdq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [VAL_W-1:0]  push_value,
	output logic                   done,
	output logic      [VAL_W-1:0]  pop_value,
	output logic      [STAT_W-1:0] status,
	output logic      [OCC_W-1:0]  occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
	logic [DEPTH-1:0]      valid_vec;

	logic [DATA_WIDTH+VAL_W-1:0] push_ext;
	logic [DATA_WIDTH+VAL_W-1:0] pop_ext;
	logic [DATA_WIDTH-1:0]       push_data;
	logic [DATA_WIDTH-1:0]       rear_data;
	logic [DATA_WIDTH-1:0]       pop_data;

	action_t  act;
	cell_op_t op;
	status_t  stat_d;
	logic     full;
	logic     empty;
	logic     is_push;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	logic              done_q;
	logic [VAL_W-1:0]  pop_value_q;
	status_t           status_q;
	logic [OCC_W-1:0]  occupancy_q;

	// The queue never holds off a command.
	assign busy = 1'b0;

	assign act     = action_t'(action);
	assign full    = valid_vec[DEPTH-1];
	assign empty   = !valid_vec[0];
	assign is_push = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_REAR);

	// Entries are DATA_WIDTH bits; the ports are fixed at 32 bits.
	assign push_ext  = (DATA_WIDTH+VAL_W)'(push_value);
	assign push_data = push_ext[DATA_WIDTH-1:0];

	// Gate the broadcast operation so refused commands leave the chain alone.
	always_comb begin
		op = '0;
		stat_d = STAT_DONE;
		if (start) begin
			unique case (act)
				ACT_PUSH_FRONT: op.push_front = !full;
				ACT_PUSH_REAR:  op.push_rear  = !full;
				ACT_POP_FRONT:  op.pop_front  = !empty;
				ACT_POP_REAR:   op.pop_rear   = !empty;
				default:        op = '0;
			endcase
			if (is_push && full) begin
				stat_d = STAT_OVERFLOW;
			end else if (!is_push && empty) begin
				stat_d = STAT_UNDERFLOW;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic                  left_valid;
		logic [DATA_WIDTH-1:0] right_data;
		logic                  right_valid;

		// Cell 0 sees the incoming value as its left neighbor.
		if (i == 0) begin : g_first
			assign left_data  = push_data;
			assign left_valid = 1'b1;
		end else begin : g_inner_left
			assign left_data  = cell_data[i-1];
			assign left_valid = valid_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data  = cell_data[i];
			assign right_valid = 1'b0;
		end else begin : g_inner_right
			assign right_data  = cell_data[i+1];
			assign right_valid = valid_vec[i+1];
		end

		cdq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.push_data  (push_data),
			.left_data  (left_data),
			.left_valid (left_valid),
			.right_data (right_data),
			.right_valid(right_valid),
			.data_q     (cell_data[i]),
			.valid_q    (valid_vec[i]),
			.tail_data  (cell_tail[i])
		);
	end

	// At most one cell flags itself as the rear entry, so an OR picks it.
	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | cell_tail[i];
		end
	end

	always_comb begin
		pop_data = '0;
		if (op.pop_front) begin
			pop_data = cell_data[0];
		end else if (op.pop_rear) begin
			pop_data = rear_data;
		end
	end

	assign pop_ext = (DATA_WIDTH+VAL_W)'(pop_data);

	always_comb begin
		count_d = count_q;
		if (op.push_front || op.push_rear) begin
			count_d = count_q + CNT_W'(1);
		end else if (op.pop_front || op.pop_rear) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// The occupancy field keeps only the low bits of the count.
	assign occ_ext = (CNT_W+OCC_W)'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pop_value_q <= pop_ext[VAL_W-1:0];
			status_q    <= stat_d;
			occupancy_q <= occ_ext[OCC_W-1:0];
		end
	end

	assign done      = done_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

	// The valid bits stay packed toward the front cell.
	`ASSERT_ALWAYS(a_thermo, clk, arst_n, ((valid_vec >> 1) & ~valid_vec) == '0)
	// The count tracks the number of occupied cells.
	`ASSERT_ALWAYS(a_count, clk, arst_n, $countones(valid_vec) == 32'(count_q))
	// Every command yields a result beat in the next cycle.
	`ASSERT_NEXT(a_result, clk, arst_n, start, done)
	// Overflow is reported only when the queue stayed full.
	`ASSERT_IMPLIES(a_ovf, clk, arst_n, done && (status_q == STAT_OVERFLOW), full)

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench of the circular deque: command driver, result monitor and predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	// The predictor keeps its own copy of the deque at the block's default size.
	localparam int DEPTH    = DEPTH_DEF;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int N_RANDOM = 700;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		action_t           act;
		logic [VAL_W-1:0]  val;
	} deque_cmd_t;

	typedef struct {
		logic [VAL_W-1:0]  pop_value;
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [ACT_W-1:0]  action = ACT_PUSH_FRONT;
	logic [VAL_W-1:0]  push_value = '0;
	logic              busy;
	logic              done;
	logic [VAL_W-1:0]  pop_value;
	logic [STAT_W-1:0] status;
	logic [OCC_W-1:0]  occupancy;

	circular_deque u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.push_value (push_value),
		.done       (done),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy)
	);

	always #2 clk = ~clk;

	// Commands waiting to be driven, and results the deque still owes us.
	deque_cmd_t    pending_cmds[$];
	deque_result_t owed_results[$];

	// Shadow deque state, updated once per accepted command beat.
	logic [VAL_W-1:0] shadow_store [DEPTH];
	logic [IDX_W-1:0] shadow_head = '0;
	logic [IDX_W-1:0] shadow_tail = '0;
	int               shadow_count = 0;

	// Run statistics for the closing summary.
	int n_beats = 0;
	int n_pushes = 0;
	int n_pops = 0;
	int n_overflows = 0;
	int n_underflows = 0;
	int n_full_hits = 0;
	int n_results = 0;
	int fail_count = 0;

	// Handshake bookkeeping between the rising-edge sampler and the falling-edge driver.
	bit beat_taken = 1'b0;
	int idle_left = 0;
	int burst_left = 0;

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_SHOWN) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
	endfunction

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	// Applies one command to the shadow deque and queues the result it must produce.
	function automatic void predict_deque(input action_t act, input logic [VAL_W-1:0] val);
		deque_result_t r;
		r.pop_value = '0;
		r.status    = STAT_DONE;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_OVERFLOW;
					n_overflows++;
				end else begin
					if (act == ACT_PUSH_FRONT) begin
						// The front moves back one slot, wrapping below zero.
						shadow_head = idx_prev(shadow_head);
						shadow_store[shadow_head] = val;
					end else begin
						shadow_store[shadow_tail] = val;
						shadow_tail = idx_next(shadow_tail);
					end
					shadow_count++;
					n_pushes++;
					if (shadow_count == DEPTH) begin
						n_full_hits++;
					end
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = STAT_UNDERFLOW;
					n_underflows++;
				end else begin
					if (act == ACT_POP_FRONT) begin
						r.pop_value = shadow_store[shadow_head];
						shadow_head = idx_next(shadow_head);
					end else begin
						// The tail points one past the rear entry, so step back first.
						shadow_tail = idx_prev(shadow_tail);
						r.pop_value = shadow_store[shadow_tail];
					end
					shadow_count--;
					n_pops++;
				end
			end
		endcase
		r.occupancy = OCC_W'(shadow_count);
		owed_results.push_back(r);
	endfunction

	// Rising edge: check any result beat against the oldest owed result, then
	// record an accepted command. The result of a command arrives in the cycle
	// after it, so checking first keeps the order obvious, though the queue
	// alone would keep it right.
	always @(posedge clk) begin : sample_edge
		deque_result_t want;
		if (arst_n) begin
			if (done !== 1'b0) begin
				n_results++;
				if (owed_results.size() == 0) begin
					note_failure($sformatf("result beat with nothing owed: pop_value=%h status=%0d occupancy=%0d",
						pop_value, status, occupancy));
				end else begin
					want = owed_results.pop_front();
					if (pop_value !== want.pop_value || status !== want.status
							|| occupancy !== want.occupancy) begin
						note_failure($sformatf({"expected pop_value=%h status=%0d occupancy=%0d, ",
							"got pop_value=%h status=%0d occupancy=%0d"},
							want.pop_value, want.status, want.occupancy,
							pop_value, status, occupancy));
					end
				end
			end
			if (start && busy === 1'b0) begin
				predict_deque(action_t'(action), push_value);
				n_beats++;
				beat_taken = 1'b1;
			end
		end
	end

	// Falling edge: hold a command until it is taken, then either idle for a
	// while or present the next one. Gaps are mostly zero or short with an
	// occasional long one, and now and then a burst of back-to-back beats.
	always @(negedge clk) begin : drive_edge
		deque_cmd_t cmd;
		int pick;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !beat_taken) begin
			// Command still waiting on busy; keep it as it is.
		end else if (idle_left > 0) begin
			start <= 1'b0;
			idle_left--;
		end else if (pending_cmds.size() != 0) begin
			cmd = pending_cmds.pop_front();
			start      <= 1'b1;
			action     <= cmd.act;
			push_value <= cmd.val;
			if (burst_left > 0) begin
				burst_left--;
				idle_left = 0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					burst_left = $urandom_range(20, 60);
					idle_left  = 0;
				end else if (pick < 50) begin
					idle_left = 0;
				end else if (pick < 88) begin
					idle_left = $urandom_range(1, 3);
				end else begin
					idle_left = $urandom_range(4, 40);
				end
			end
		end else begin
			start <= 1'b0;
		end
		beat_taken = 1'b0;
	end

	task automatic queue_cmd(input action_t act, input logic [VAL_W-1:0] val);
		deque_cmd_t c;
		c.act = act;
		c.val = val;
		pending_cmds.push_back(c);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return '1;
			2: return VAL_W'(1) << $urandom_range(0, VAL_W - 1);
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int issued;
		int run_len;
		int push_pct;
		int kind;
		int settle;
		action_t act;

		// Directed opening. Pops on the empty deque must underflow at both ends.
		queue_cmd(ACT_POP_FRONT, 32'hFFFF_FFFF);
		queue_cmd(ACT_POP_REAR,  32'h0000_0000);
		// A rear push into an empty deque must set up the front as well.
		queue_cmd(ACT_PUSH_REAR, 32'hFFFF_FFFF);
		queue_cmd(ACT_POP_FRONT, 32'h1234_5678);
		// Likewise a front push into an empty deque, taken back from the rear.
		queue_cmd(ACT_PUSH_FRONT, 32'h0000_0000);
		queue_cmd(ACT_POP_REAR,   32'hDEAD_BEEF);
		// Front push wraps the head below slot zero; rear push follows.
		queue_cmd(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
		queue_cmd(ACT_PUSH_REAR,  32'h5555_5555);
		queue_cmd(ACT_PUSH_FRONT, 32'h8000_0001);
		queue_cmd(ACT_POP_FRONT,  32'h0000_0000);
		queue_cmd(ACT_POP_REAR,   32'h0000_0000);
		queue_cmd(ACT_POP_REAR,   32'h0000_0000);
		queue_cmd(ACT_POP_FRONT,  32'hFFFF_FFFF);

		// Random part in phases: filling phases drive the deque to full and into
		// overflow, draining phases empty it and hit underflow, and mixed phases
		// wander both ways so the indices wrap in both directions. The first
		// phase always fills.
		issued = 0;
		kind = 0;
		while (issued < N_RANDOM) begin
			run_len = $urandom_range(10, 60);
			push_pct = (kind < 4) ? 85 : (kind < 7) ? 15 : 50;
			repeat (run_len) begin
				if ($urandom_range(0, 99) < push_pct) begin
					act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
				end else begin
					act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
				end
				queue_cmd(act, pick_value());
				issued++;
			end
			kind = $urandom_range(0, 9);
		end

		// Reset once, released on a falling edge so the driver starts on the next falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every command to be taken, then for the owed results.
		while (pending_cmds.size() != 0 || start) @(negedge clk);
		settle = 0;
		while (owed_results.size() != 0 && settle < 100) begin
			@(negedge clk);
			settle++;
		end
		// The extra wait catches any stray result beat.
		repeat (4) @(negedge clk);
		while (owed_results.size() != 0) begin
			void'(owed_results.pop_front());
			note_failure("result owed by the deque never arrived");
		end

		$display("Covered %0d command beats and %0d result beats: %0d pushes, %0d pops,",
			n_beats, n_results, n_pushes, n_pops);
		$display("%0d overflows, %0d underflows, deque filled %0d times; %0d failures.",
			n_overflows, n_underflows, n_full_hits, fail_count);
		if (fail_count == 0) begin
			$display("[circular_deque] OK");
		end else begin
			$display("[circular_deque] ERROR");
		end
		$finish;
	end

	// Watchdog: the slowest legal run is well under a tenth of this.
	initial begin : watchdog
		#2_000_000;
		$display("[circular_deque] ERROR");
		$finish;
	end

endmodule
